// File: hdl/ppg_pkg.sv
// ppg pulse rate detector: shared widths, register indexes, reset values and types
package ppg_pkg;

  // configuration port
  localparam int CFG_W     = 21;
  localparam int CFG_IDX_W = 3;

  // register field widths
  localparam int ALPHA_W = 15;
  localparam int THR_W   = 21;
  localparam int PRES_W  = 18;
  localparam int WIN_W   = 10;
  localparam int NUM_W   = 20;
  localparam int PER_W   = 8;

  // datapath widths
  localparam int DC_W   = 25;
  localparam int DCR_W  = 20;
  localparam int NORM_W = 21;
  localparam int BPM_W  = 8;
  localparam int BEAT_W = 3;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  typedef logic [BPM_W-1:0]     bpm_t;

  // register indexes
  localparam cfg_idx_t REG_DC_ALPHA      = 3'd0;
  localparam cfg_idx_t REG_HIGH_THRESH   = 3'd1;
  localparam cfg_idx_t REG_LOW_THRESH    = 3'd2;
  localparam cfg_idx_t REG_PRES_THRESH   = 3'd3;
  localparam cfg_idx_t REG_WINDOW_LENGTH = 3'd4;
  localparam cfg_idx_t REG_RATE_NUM      = 3'd5;
  localparam cfg_idx_t REG_SAMPLE_PERIOD = 3'd6;

  // register reset values
  localparam logic [ALPHA_W-1:0]      RST_DC_ALPHA      = 15'd31130;
  localparam logic signed [THR_W-1:0] RST_HIGH_THRESH   = 21'sd19;
  localparam logic signed [THR_W-1:0] RST_LOW_THRESH    = -21'sd10;
  localparam logic [PRES_W-1:0]       RST_PRES_THRESH   = 18'd1000;
  localparam logic [WIN_W-1:0]        RST_WINDOW_LENGTH = 10'd1000;
  localparam logic [NUM_W-1:0]        RST_RATE_NUM      = 20'd240000;
  localparam logic [PER_W-1:0]        RST_SAMPLE_PERIOD = 8'd11;

  // beat and rate limits
  localparam logic [BEAT_W-1:0] BEATS_PER_RATE = 3'd5;
  localparam bpm_t BPM_LOW  = 8'd20;
  localparam bpm_t BPM_HIGH = 8'd200;
  localparam bpm_t BPM_SAT  = 8'd255;

endpackage

// File: hdl/ppg_ser_mul.sv
// ppg serial multiplier: unsigned by signed, one multiplier bit a cycle, quotient by 2^A_W toward zero
module ppg_ser_mul #(
  parameter int A_W = 15,
  parameter int B_W = 25
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [A_W-1:0]        a,
  input  logic signed [B_W-1:0] b,
  output logic                  done,
  output logic signed [B_W-1:0] q
);

  localparam int CNT_W = $clog2(A_W);

  logic                  busy;
  logic [CNT_W-1:0]      cnt;
  logic [A_W-1:0]        a_sh;
  logic signed [B_W-1:0] b_reg;
  logic signed [B_W:0]   acc;
  logic [A_W-1:0]        low;
  logic signed [B_W:0]   sum;

  // partial sum, then shift right: low bits leave into low
  assign sum = acc + (a_sh[0] ? {b_reg[B_W-1], b_reg} : '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(A_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_sh  <= a;
      b_reg <= b;
      acc   <= '0;
      low   <= '0;
    end else if (busy) begin
      acc  <= sum >>> 1;
      low  <= {sum[0], low[A_W-1:1]};
      a_sh <= a_sh >> 1;
    end
  end

  // acc is the floor; step up by one for a negative product with a remainder
  assign q = acc[B_W-1:0] + {{(B_W-1){1'b0}}, acc[B_W] & (|low)};

endmodule

// File: hdl/ppg_ser_div.sv
// ppg serial divider: restoring unsigned division, one quotient bit a cycle
module ppg_ser_div #(
  parameter int N_W = 23,
  parameter int D_W = 24
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic [N_W-1:0] dividend,
  input  logic [D_W-1:0] divisor,
  output logic           done,
  output logic [N_W-1:0] quotient
);

  localparam int CNT_W = $clog2(N_W);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [N_W-1:0]   quo;
  logic [D_W-1:0]   rem;
  logic [D_W-1:0]   dvs;
  logic [D_W:0]     trial;
  logic [D_W:0]     rem_step;
  logic             ge;

  assign trial    = {rem, quo[N_W-1]};
  assign ge       = trial >= {1'b0, dvs};
  assign rem_step = ge ? (trial - {1'b0, dvs}) : trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(N_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // dividend shifts out at the top while quotient bits shift in at the bottom
  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      quo <= {quo[N_W-2:0], ge};
      rem <= rem_step[D_W-1:0];
    end
  end

  // a zero divisor gives all ones, which saturates downstream
  assign quotient = quo;

endmodule

// File: hdl/ppg_pulse_rate_detector.sv
// ppg pulse rate detector: top level, sequencer around a serial multiplier and a serial divider
// sequence: an item taken before a finger is present goes S_IDLE, S_DONE; a processed item
//   runs S_MUL (15 multiply steps), S_UPD, S_SUM, S_DSTM, S_DIVM (23 divide steps for the
//   mean) and S_BEAT, plus S_RSTART and S_DIVR when a fifth beat triggers the rate division;
//   every item then waits in S_DONE until the output register is free
// throughput: one item at a time, the next is taken once the result is in the output register
// reset: synchronous active high rst clears state, filter history, counters, presets config
module ppg_pulse_rate_detector #(
  parameter int MEAN_TAPS   = 5,
  parameter int SAMPLE_BITS = 18,
  parameter int COUNT_BITS  = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  // configuration write port
  input  logic                                cfg_wr_en,
  input  ppg_pkg::cfg_idx_t                   cfg_index,
  input  logic [ppg_pkg::CFG_W-1:0]           cfg_data,
  // sample channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [SAMPLE_BITS-1:0]              red_sample,
  input  logic [SAMPLE_BITS-1:0]              ir_sample,
  // result channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                active,
  output logic signed [ppg_pkg::DCR_W-1:0]    dc_removed,
  output logic signed [ppg_pkg::NORM_W-1:0]   normalised,
  output logic                                beat_event,
  output logic                                rate_ready,
  output ppg_pkg::bpm_t                       rate_bpm,
  output logic                                rate_changed
);

  import ppg_pkg::*;

  localparam int IDX_W      = $clog2(MEAN_TAPS);
  localparam int SUM_W      = DCR_W + $clog2(MEAN_TAPS);
  localparam int DIV_N_W    = (SUM_W > NUM_W) ? SUM_W : NUM_W;
  localparam int DIV_D_W    = PER_W + COUNT_BITS;
  localparam int PRES_CMP_W = (SAMPLE_BITS > PRES_W) ? SAMPLE_BITS : PRES_W;
  localparam int TMP_W      = DC_W + 2;

  // sequencer states
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_MUL    = 4'd1;  // dc filter product, bit serial
  localparam logic [3:0] S_UPD    = 4'd2;  // dc filter update
  localparam logic [3:0] S_DSTM   = 4'd3;  // launch mean division
  localparam logic [3:0] S_DIVM   = 4'd4;
  localparam logic [3:0] S_BEAT   = 4'd5;  // hysteresis and counters
  localparam logic [3:0] S_RSTART = 4'd6;  // launch rate division
  localparam logic [3:0] S_DIVR   = 4'd7;
  localparam logic [3:0] S_DONE   = 4'd8;  // hand over to the output register
  localparam logic [3:0] S_SUM    = 4'd9;  // moving sum update

  // configuration registers
  logic [ALPHA_W-1:0]      dc_alpha;
  logic signed [THR_W-1:0] high_threshold;
  logic signed [THR_W-1:0] low_threshold;
  logic [PRES_W-1:0]       presence_threshold;
  logic [WIN_W-1:0]        window_length;
  logic [NUM_W-1:0]        rate_numerator;
  logic [PER_W-1:0]        sample_period;

  // block state
  logic [3:0]                state;
  logic                      running;
  logic signed [DC_W-1:0]    dc_prev;
  logic signed [DCR_W-1:0]   mean_taps [MEAN_TAPS];
  logic signed [SUM_W-1:0]   mean_sum;
  logic [IDX_W-1:0]          tap_index;
  logic [WIN_W-1:0]          window_count;
  logic [COUNT_BITS-1:0]     interval_count;
  logic [BEAT_W-1:0]         beat_count;
  logic                      above_flag;
  bpm_t                      last_rate;

  // working registers for the item in flight
  logic [SAMPLE_BITS-1:0]    red_reg;
  logic                      active_w;
  logic signed [DCR_W-1:0]   dcr_w;
  logic signed [NORM_W-1:0]  norm_w;
  logic                      beat_w;
  logic                      ready_w;
  bpm_t                      bpm_w;
  logic                      changed_w;
  logic                      mean_neg;
  logic [COUNT_BITS-1:0]     rate_cnt;

  // handshake
  logic accept;
  logic out_free;
  logic present;

  // arithmetic units
  logic                      mul_start;
  logic                      mul_done;
  logic signed [DC_W-1:0]    mul_q;
  logic                      div_start;
  logic                      div_done;
  logic [DIV_N_W-1:0]        div_dividend;
  logic [DIV_D_W-1:0]        div_divisor;
  logic [DIV_N_W-1:0]        div_q;

  // filter datapath
  logic signed [TMP_W-1:0]   temp;
  logic signed [DC_W-1:0]    temp_sat;
  logic signed [DC_W:0]      dcr_diff;
  logic signed [DCR_W-1:0]   dcr_sat;
  logic signed [DCR_W-1:0]   tap_old;
  logic signed [SUM_W-1:0]   sum_new;
  logic [IDX_W-1:0]          idx_next;
  logic [SUM_W-1:0]          sum_mag;

  // beat datapath
  logic [DCR_W-1:0]          mean_q;
  logic signed [NORM_W-1:0]  mean_s;
  logic signed [NORM_W-1:0]  norm;
  logic [WIN_W-1:0]          window_inc;
  logic                      window_end;
  logic [COUNT_BITS-1:0]     interval_inc;
  logic [COUNT_BITS-1:0]     interval_next;
  logic                      beat_hit;
  logic [BEAT_W-1:0]         beat_next;
  logic                      above_next;
  logic                      rate_go;

  // rate datapath
  bpm_t                      rate_sat;
  logic                      rate_ok;

  assign in_stall = rst | (state != S_IDLE);
  assign accept   = in_valid & ~in_stall;
  assign out_free = ~out_valid | ~out_stall;

  // finger presence on either channel
  assign present = (PRES_CMP_W'(red_sample) > PRES_CMP_W'(presence_threshold))
                 | (PRES_CMP_W'(ir_sample) > PRES_CMP_W'(presence_threshold));

  // ---------------------------------------------------------------------------
  // configuration writes
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      dc_alpha           <= RST_DC_ALPHA;
      high_threshold     <= RST_HIGH_THRESH;
      low_threshold      <= RST_LOW_THRESH;
      presence_threshold <= RST_PRES_THRESH;
      window_length      <= RST_WINDOW_LENGTH;
      rate_numerator     <= RST_RATE_NUM;
      sample_period      <= RST_SAMPLE_PERIOD;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_DC_ALPHA:      dc_alpha           <= cfg_data[ALPHA_W-1:0];
        REG_HIGH_THRESH:   high_threshold     <= cfg_data[THR_W-1:0];
        REG_LOW_THRESH:    low_threshold      <= cfg_data[THR_W-1:0];
        REG_PRES_THRESH:   presence_threshold <= cfg_data[PRES_W-1:0];
        REG_WINDOW_LENGTH: window_length      <= cfg_data[WIN_W-1:0];
        REG_RATE_NUM:      rate_numerator     <= cfg_data[NUM_W-1:0];
        REG_SAMPLE_PERIOD: sample_period      <= cfg_data[PER_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // serial units
  // ---------------------------------------------------------------------------
  assign mul_start = accept & running;

  ppg_ser_mul #(
    .A_W (ALPHA_W),
    .B_W (DC_W)
  ) u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (dc_alpha),
    .b     (dc_prev),
    .done  (mul_done),
    .q     (mul_q)
  );

  // shared divider: mean magnitude by tap count, or numerator by period times interval
  assign div_start    = (state == S_DSTM) | (state == S_RSTART);
  assign div_dividend = (state == S_RSTART) ? DIV_N_W'(rate_numerator) : DIV_N_W'(sum_mag);
  assign div_divisor  = (state == S_RSTART)
                      ? ({{COUNT_BITS{1'b0}}, sample_period} * {{PER_W{1'b0}}, rate_cnt})
                      : DIV_D_W'(MEAN_TAPS);

  ppg_ser_div #(
    .N_W (DIV_N_W),
    .D_W (DIV_D_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_q)
  );

  // ---------------------------------------------------------------------------
  // dc removal and moving sum
  // ---------------------------------------------------------------------------
  always_comb begin
    temp = {{(TMP_W-SAMPLE_BITS){1'b0}}, red_reg} + {{2{mul_q[DC_W-1]}}, mul_q};
    // saturate the filter state to its own width
    if (temp[TMP_W-1:DC_W-1] != {(TMP_W-DC_W+1){temp[TMP_W-1]}}) begin
      temp_sat = temp[TMP_W-1] ? {1'b1, {(DC_W-1){1'b0}}} : {1'b0, {(DC_W-1){1'b1}}};
    end else begin
      temp_sat = temp[DC_W-1:0];
    end
    dcr_diff = {temp_sat[DC_W-1], temp_sat} - {dc_prev[DC_W-1], dc_prev};
    if (dcr_diff[DC_W:DCR_W-1] != {(DC_W-DCR_W+2){dcr_diff[DC_W]}}) begin
      dcr_sat = dcr_diff[DC_W] ? {1'b1, {(DCR_W-1){1'b0}}} : {1'b0, {(DCR_W-1){1'b1}}};
    end else begin
      dcr_sat = dcr_diff[DCR_W-1:0];
    end
    // moving sum works from the registered filter output
    tap_old  = mean_taps[tap_index];
    sum_new  = mean_sum - SUM_W'(tap_old) + SUM_W'(dcr_w);
    idx_next = (tap_index == IDX_W'(MEAN_TAPS - 1)) ? '0 : tap_index + 1'b1;
    // magnitude for a division that truncates toward zero
    sum_mag  = mean_sum[SUM_W-1] ? (~mean_sum + 1'b1) : mean_sum;
  end

  // ---------------------------------------------------------------------------
  // mean difference, hysteresis and counters
  // ---------------------------------------------------------------------------
  always_comb begin
    mean_q        = div_q[DCR_W-1:0];
    mean_s        = mean_neg ? -$signed({1'b0, mean_q}) : $signed({1'b0, mean_q});
    norm          = mean_s - {dcr_w[DCR_W-1], dcr_w};
    window_inc    = window_count + 1'b1;
    window_end    = window_inc >= window_length;
    interval_inc  = (interval_count == '1) ? interval_count : interval_count + 1'b1;
    beat_hit      = (norm > high_threshold) & ~above_flag;
    beat_next     = beat_hit ? beat_count + 1'b1 : beat_count;
    // the first beat of a measurement starts the interval afresh
    interval_next = (beat_hit && beat_next == BEAT_W'(1)) ? '0 : interval_inc;
    above_next    = (norm < low_threshold) ? 1'b0 : (beat_hit | above_flag);
    rate_go       = beat_next >= BEATS_PER_RATE;
  end

  // rate saturates at the top and must lie strictly inside the band
  assign rate_sat = (|div_q[DIV_N_W-1:BPM_W]) ? BPM_SAT : div_q[BPM_W-1:0];
  assign rate_ok  = (rate_sat > BPM_LOW) & (rate_sat < BPM_HIGH);

  // ---------------------------------------------------------------------------
  // sequencer and state
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      running        <= 1'b0;
      dc_prev        <= '0;
      for (int i = 0; i < MEAN_TAPS; i++) begin
        mean_taps[i] <= '0;
      end
      mean_sum       <= '0;
      tap_index      <= '0;
      window_count   <= '0;
      interval_count <= '0;
      beat_count     <= '0;
      above_flag     <= 1'b0;
      last_rate      <= '0;
      out_valid      <= 1'b0;
    end else begin
      // a result taken while the next one is ready is replaced in S_DONE
      if (out_valid && !out_stall && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (running) begin
              state <= S_MUL;
            end else begin
              // the triggering sample itself is not processed
              if (present) begin
                running <= 1'b1;
              end
              state <= S_DONE;
            end
          end
        end
        S_MUL: begin
          if (mul_done) begin
            state <= S_UPD;
          end
        end
        S_UPD: begin
          dc_prev <= temp_sat;
          state   <= S_SUM;
        end
        S_SUM: begin
          mean_taps[tap_index] <= dcr_w;
          mean_sum             <= sum_new;
          tap_index            <= idx_next;
          state                <= S_DSTM;
        end
        S_DSTM: begin
          state <= S_DIVM;
        end
        S_DIVM: begin
          if (div_done) begin
            state <= S_BEAT;
          end
        end
        S_BEAT: begin
          if (rate_go || window_end) begin
            beat_count     <= '0;
            interval_count <= '0;
            above_flag     <= 1'b0;
          end else begin
            beat_count     <= beat_next;
            interval_count <= interval_next;
            above_flag     <= above_next;
          end
          window_count <= window_end ? '0 : window_inc;
          state        <= rate_go ? S_RSTART : S_DONE;
        end
        S_RSTART: begin
          state <= S_DIVR;
        end
        S_DIVR: begin
          if (div_done) begin
            if (rate_ok) begin
              last_rate <= rate_sat;
            end
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // item payload and output register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (accept) begin
          red_reg   <= red_sample;
          active_w  <= running;
          dcr_w     <= '0;
          norm_w    <= '0;
          beat_w    <= 1'b0;
          ready_w   <= 1'b0;
          bpm_w     <= '0;
          changed_w <= 1'b0;
        end
      end
      S_UPD: begin
        dcr_w <= dcr_sat;
      end
      S_DSTM: begin
        mean_neg <= mean_sum[SUM_W-1];
      end
      S_BEAT: begin
        norm_w   <= norm;
        beat_w   <= beat_hit;
        rate_cnt <= interval_next;
      end
      S_DIVR: begin
        if (div_done && rate_ok) begin
          ready_w   <= 1'b1;
          bpm_w     <= rate_sat;
          changed_w <= rate_sat != last_rate;
        end
      end
      S_DONE: begin
        if (out_free) begin
          active       <= active_w;
          dc_removed   <= dcr_w;
          normalised   <= norm_w;
          beat_event   <= beat_w;
          rate_ready   <= ready_w;
          rate_bpm     <= bpm_w;
          rate_changed <= changed_w;
        end
      end
      default: ;
    endcase
  end

endmodule

// File: hdl/ppg_chk.sv
// ppg pulse rate detector: port checker and its bind to the top level
module ppg_chk (
  input logic                              clk,
  input logic                              rst,
  input logic                              in_valid,
  input logic                              in_stall,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic                              active,
  input logic signed [ppg_pkg::DCR_W-1:0]  dc_removed,
  input logic signed [ppg_pkg::NORM_W-1:0] normalised,
  input logic                              beat_event,
  input logic                              rate_ready,
  input ppg_pkg::bpm_t                     rate_bpm,
  input logic                              rate_changed
);

  import ppg_pkg::*;

  // an item that was not processed carries nothing but zeros
  a_idle_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !active |-> dc_removed == '0 && normalised == '0 && !beat_event
                             && !rate_ready && rate_bpm == '0 && !rate_changed)
    else $error("inactive result with non-zero fields");

  // rate fields stay clear unless a rate is reported
  a_rate_clear: assert property (@(posedge clk) disable iff (rst)
    out_valid && !rate_ready |-> rate_bpm == '0 && !rate_changed)
    else $error("rate fields set without rate_ready");

  // a reported rate lies strictly inside the band
  a_rate_band: assert property (@(posedge clk) disable iff (rst)
    out_valid && rate_ready |-> rate_bpm > BPM_LOW && rate_bpm < BPM_HIGH)
    else $error("reported rate outside band");

  // one item in flight: the block is busy in the cycle after an accept
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("second item accepted back to back");

endmodule

bind ppg_pulse_rate_detector ppg_chk u_ppg_chk (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .active       (active),
  .dc_removed   (dc_removed),
  .normalised   (normalised),
  .beat_event   (beat_event),
  .rate_ready   (rate_ready),
  .rate_bpm     (rate_bpm),
  .rate_changed (rate_changed)
);
